[src/rcfp_pkg.sv]
// Package for the RC serial frame parser: parser phase codes, result status
// codes, and the types that pass between the front end, the queue and the back end.
// No dependencies.
package rcfp_pkg;

   // Width of the data fill index; it wraps modulo 64.
   localparam int FILL_W = 6;

   // Parser phases.
   localparam logic [2:0] PH_LEN    = 3'd0;
   localparam logic [2:0] PH_TYPE   = 3'd1;
   localparam logic [2:0] PH_DATA   = 3'd2;
   localparam logic [2:0] PH_CRC_LO = 3'd3;
   localparam logic [2:0] PH_CRC_HI = 3'd4;

   // Result status codes.
   localparam logic [1:0] ST_DATA    = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_CRC_ERR = 2'd2;
   localparam logic [1:0] ST_LEN_ERR = 2'd3;

   // Value the running checksum starts from.
   localparam logic [15:0] SUM_INIT = 16'hFFFF;

   // Frame-end command from the front end to the back end.
   typedef struct packed {
      logic [1:0]        kind;
      logic [7:0]        frame_type;
      logic [FILL_W-1:0] count;
      logic [15:0]       error_count;
   } frame_cmd_type;

   // Write port of the payload buffer.
   typedef struct packed {
      logic              en;
      logic [FILL_W-1:0] addr;
      logic [7:0]        data;
   } mem_wr_type;

endpackage

[src/rcfp_channels.sv]
// Valid/ready channel interfaces of the RC serial frame parser: the byte
// input channel and the result channel. No dependencies.
interface rcfp_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] byte_value;

   modport source (output valid, output cmd, output byte_value, input ready);
   modport sink (input valid, input cmd, input byte_value, output ready);
endinterface

interface rcfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  frame_type;
   logic [4:0]  byte_index;
   logic [7:0]  data_byte;
   logic        last;
   logic [15:0] error_count;

   modport source (output valid, output status, output frame_type, output byte_index,
                   output data_byte, output last, output error_count, input ready);
   modport sink (input valid, input status, input frame_type, input byte_index,
                 input data_byte, input last, input error_count, output ready);
endinterface

[src/rcfp_front.sv]
// Front end of the RC serial frame parser: accepts byte and gap beats, runs
// the frame state machine, and fills the payload buffer. Depends on rcfp_pkg, rcfp_req_if.
module rcfp_front #(
   parameter int DATA_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   rcfp_req_if.sink              req,
   input  logic                  q_full,
   input  logic                  back_busy,
   output logic                  push_valid,
   output rcfp_pkg::frame_cmd_type push_data,
   output rcfp_pkg::mem_wr_type  mem_wr
);
   import rcfp_pkg::*;

   localparam logic [8:0]        MAX_LEN   = 9'(DATA_DEPTH + 4);
   localparam logic [FILL_W:0]   DEPTH_EXT = (FILL_W + 1)'(DATA_DEPTH);

   logic [2:0]        phase_ff, phase_in;
   logic [7:0]        bytes_left_ff, bytes_left_in;
   logic [15:0]       sum_ff, sum_in;
   logic [7:0]        type_ff, type_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        sum_low_ff, sum_low_in;
   logic [15:0]       fail_ff, fail_in;
   logic              accept;
   logic [7:0]        ch;
   logic [FILL_W:0]   fill_ext;
   logic [FILL_W-1:0] burst_cnt;

   // The buffer must not be refilled while the back end still reads a frame.
   assign req.ready = !q_full && !(phase_ff == PH_DATA && back_busy);
   assign accept    = req.valid && req.ready;
   assign ch        = req.byte_value;
   assign fill_ext  = {1'b0, fill_ff};
   assign burst_cnt = (fill_ext > DEPTH_EXT) ? DEPTH_EXT[FILL_W-1:0] : fill_ff;

   // Frame state machine.
   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      sum_in        = sum_ff;
      type_in       = type_ff;
      fill_in       = fill_ff;
      sum_low_in    = sum_low_ff;
      fail_in       = fail_ff;
      push_valid    = 1'b0;
      push_data     = '0;
      mem_wr        = '0;
      if (accept) begin
         if (req.cmd) begin
            phase_in      = PH_LEN;
            bytes_left_in = '0;
            sum_in        = SUM_INIT;
            fill_in       = '0;
         end else begin
            unique case (phase_ff)
               PH_TYPE: begin
                  bytes_left_in = bytes_left_ff - 8'd1;
                  sum_in        = sum_ff - {8'h00, ch};
                  type_in       = ch;
                  phase_in      = (bytes_left_in > 8'd2) ? PH_DATA : PH_CRC_LO;
               end
               PH_DATA: begin
                  mem_wr.en     = (fill_ext < DEPTH_EXT);
                  mem_wr.addr   = fill_ff;
                  mem_wr.data   = ch;
                  fill_in       = fill_ff + FILL_W'(1);
                  bytes_left_in = bytes_left_ff - 8'd1;
                  sum_in        = sum_ff - {8'h00, ch};
                  if (bytes_left_in <= 8'd2) begin
                     phase_in = PH_CRC_LO;
                  end
               end
               PH_CRC_LO: begin
                  sum_low_in = ch;
                  phase_in   = PH_CRC_HI;
               end
               PH_CRC_HI: begin
                  push_valid           = 1'b1;
                  push_data.frame_type = type_ff;
                  if ({ch, sum_low_ff} == sum_ff) begin
                     push_data.kind  = (fill_ff == '0) ? ST_EMPTY : ST_DATA;
                     push_data.count = burst_cnt;
                  end else begin
                     if (fail_ff != 16'hFFFF) begin
                        fail_in = fail_ff + 16'd1;
                     end
                     push_data.kind = ST_CRC_ERR;
                  end
                  push_data.error_count = fail_in;
                  phase_in      = PH_LEN;
                  bytes_left_in = '0;
                  sum_in        = SUM_INIT;
                  fill_in       = '0;
               end
               default: begin
                  // Length byte; unused phase codes behave the same way.
                  if (ch < 8'd4 || {1'b0, ch} > MAX_LEN) begin
                     push_valid            = 1'b1;
                     push_data.kind        = ST_LEN_ERR;
                     push_data.error_count = fail_ff;
                     phase_in      = PH_LEN;
                     bytes_left_in = '0;
                     sum_in        = SUM_INIT;
                     fill_in       = '0;
                  end else begin
                     bytes_left_in = ch - 8'd1;
                     sum_in        = SUM_INIT - {8'h00, ch};
                     fill_in       = '0;
                     phase_in      = PH_TYPE;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEN;
         bytes_left_ff <= '0;
         sum_ff        <= SUM_INIT;
         type_ff       <= '0;
         fill_ff       <= '0;
         sum_low_ff    <= '0;
         fail_ff       <= '0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         sum_ff        <= sum_in;
         type_ff       <= type_in;
         fill_ff       <= fill_in;
         sum_low_ff    <= sum_low_in;
         fail_ff       <= fail_in;
      end
   end

endmodule

[src/rcfp_queue.sv]
// Two-entry command queue between the front and back ends of the RC serial
// frame parser. Depends on rcfp_pkg.
module rcfp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rcfp_pkg::frame_cmd_type push_data,
   input  logic                    pop,
   output rcfp_pkg::frame_cmd_type pop_data,
   output logic                    full,
   output logic                    empty
);
   import rcfp_pkg::*;

   frame_cmd_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/rcfp_back.sv]
// Back end of the RC serial frame parser: holds the payload buffer, takes
// frame-end commands from the queue and sends result beats. Depends on rcfp_pkg, rcfp_rsp_if.
module rcfp_back #(
   parameter int DATA_DEPTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rcfp_pkg::mem_wr_type    mem_wr,
   input  rcfp_pkg::frame_cmd_type cmd,
   input  logic                    q_empty,
   output logic                    pop,
   output logic                    busy,
   rcfp_rsp_if.source              rsp
);
   import rcfp_pkg::*;

   localparam int AW = $clog2(DATA_DEPTH);

   logic [7:0]        payload_mem [DATA_DEPTH];

   // Command being worked on.
   logic              cur_valid_ff, cur_valid_in;
   logic [1:0]        cur_kind_ff, cur_kind_in;
   logic [7:0]        cur_type_ff, cur_type_in;
   logic [FILL_W-1:0] cur_cnt_ff, cur_cnt_in;
   logic [FILL_W-1:0] cur_idx_ff, cur_idx_in;
   logic [15:0]       cur_err_ff, cur_err_in;

   // Read stage: one beat whose buffer read is in flight.
   logic              pend_valid_ff, pend_valid_in;
   logic [1:0]        pend_status_ff;
   logic [7:0]        pend_type_ff;
   logic [4:0]        pend_idx_ff;
   logic              pend_last_ff;
   logic [15:0]       pend_err_ff;
   logic              pend_is_data_ff;
   logic [7:0]        rd_data_ff;

   // Output register.
   logic              out_valid_ff, out_valid_in;
   logic [1:0]        out_status_ff;
   logic [7:0]        out_type_ff;
   logic [4:0]        out_idx_ff;
   logic [7:0]        out_data_ff;
   logic              out_last_ff;
   logic [15:0]       out_err_ff;

   logic              load_out, issue, issue_last, is_burst;
   logic [FILL_W:0]   idx_next;

   assign load_out   = pend_valid_ff && (!out_valid_ff || rsp.ready);
   assign issue      = cur_valid_ff && (!pend_valid_ff || load_out);
   assign is_burst   = (cur_kind_ff == ST_DATA);
   assign idx_next   = {1'b0, cur_idx_ff} + (FILL_W + 1)'(1);
   assign issue_last = !is_burst || (idx_next == {1'b0, cur_cnt_ff});
   assign pop        = !cur_valid_ff && !q_empty;
   assign busy       = cur_valid_ff || !q_empty;

   // Command sequencing: a burst sends one beat per issued read.
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_kind_in  = cur_kind_ff;
      cur_type_in  = cur_type_ff;
      cur_cnt_in   = cur_cnt_ff;
      cur_idx_in   = cur_idx_ff;
      cur_err_in   = cur_err_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_kind_in  = cmd.kind;
         cur_type_in  = cmd.frame_type;
         cur_cnt_in   = cmd.count;
         cur_idx_in   = '0;
         cur_err_in   = cmd.error_count;
      end else if (issue) begin
         cur_idx_in = idx_next[FILL_W-1:0];
         if (issue_last) begin
            cur_valid_in = 1'b0;
         end
      end
      pend_valid_in = issue || (pend_valid_ff && !load_out);
      out_valid_in  = load_out || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cur_valid_ff  <= cur_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload fields of the command, read and output stages.
   always_ff @(posedge clock) begin
      cur_kind_ff <= cur_kind_in;
      cur_type_ff <= cur_type_in;
      cur_cnt_ff  <= cur_cnt_in;
      cur_idx_ff  <= cur_idx_in;
      cur_err_ff  <= cur_err_in;
      if (issue) begin
         pend_status_ff  <= cur_kind_ff;
         pend_type_ff    <= (cur_kind_ff == ST_LEN_ERR) ? 8'h00 : cur_type_ff;
         pend_idx_ff     <= is_burst ? cur_idx_ff[4:0] : 5'd0;
         pend_last_ff    <= issue_last;
         pend_err_ff     <= cur_err_ff;
         pend_is_data_ff <= is_burst;
      end
      if (load_out) begin
         out_status_ff <= pend_status_ff;
         out_type_ff   <= pend_type_ff;
         out_idx_ff    <= pend_idx_ff;
         out_data_ff   <= pend_is_data_ff ? rd_data_ff : 8'h00;
         out_last_ff   <= pend_last_ff;
         out_err_ff    <= pend_err_ff;
      end
   end

   // Payload buffer: written by the front end, read one entry per issued beat.
   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         payload_mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
      end
      if (issue) begin
         rd_data_ff <= payload_mem[cur_idx_ff[AW-1:0]];
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.status      = out_status_ff;
   assign rsp.frame_type  = out_type_ff;
   assign rsp.byte_index  = out_idx_ff;
   assign rsp.data_byte   = out_data_ff;
   assign rsp.last        = out_last_ff;
   assign rsp.error_count = out_err_ff;

`ifndef SYNTH
   // The buffer is never refilled while a command is still being read out.
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_wr.en |-> !cur_valid_ff)
      else $error("payload write while back end is busy");

   // A burst never reads past the end of its frame data.
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (issue && is_burst) |-> (cur_idx_ff < cur_cnt_ff))
      else $error("burst read index beyond frame data");

   // A burst command always carries at least one data byte.
   a_burst_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cur_valid_ff && is_burst) |-> (cur_cnt_ff != '0))
      else $error("burst command with zero count");

   // A popped command is being worked on in the next cycle.
   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      pop |=> cur_valid_ff)
      else $error("popped command was not loaded");
`endif

endmodule

[src/rc_serial_frame_parser.sv]
// Top level of the RC serial frame parser: front end, command queue and back end.
// Depends on rcfp_pkg, rcfp_req_if, rcfp_rsp_if, rcfp_front, rcfp_queue, rcfp_back.
//
// Usage: the req_chan channel carries one beat per received serial byte
// (cmd 0) or per line-idle gap (cmd 1, which resynchronizes the parser).
// The rsp_chan channel carries result beats: the data bytes of a frame with
// a good checksum, in order, or one status beat for an empty frame, a
// checksum error or a length error. The final beat caused by an input has
// last set.
// Throughput: one input beat per cycle while req_chan is ready. A frame end with N
// data bytes sends N result beats back to back; the first passes through the command
// queue, the command register, the buffer read stage and the output register. The
// next frame's data bytes are held off until the last buffer read of the previous
// burst.
// Reset clears the parser, the queue, the error counter and all pending
// results. When the receiver stalls, results wait in the output register
// and read stage while input beats keep being accepted until the two-entry
// command queue fills or a new frame's data must go into the buffer.
module rc_serial_frame_parser #(
   parameter int DATA_DEPTH = 32
) (
   input logic        clock,
   input logic        reset,
   rcfp_req_if.sink   req_chan,
   rcfp_rsp_if.source rsp_chan
);
   import rcfp_pkg::*;

   frame_cmd_type push_data, pop_data;
   mem_wr_type    mem_wr;
   logic          push_valid, pop, q_full, q_empty, back_busy;

   rcfp_front #(.DATA_DEPTH(DATA_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .q_full     (q_full),
      .back_busy  (back_busy),
      .push_valid (push_valid),
      .push_data  (push_data),
      .mem_wr     (mem_wr)
   );

   rcfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   rcfp_back #(.DATA_DEPTH(DATA_DEPTH)) u_back (
      .clock   (clock),
      .reset   (reset),
      .mem_wr  (mem_wr),
      .cmd     (pop_data),
      .q_empty (q_empty),
      .pop     (pop),
      .busy    (back_busy),
      .rsp     (rsp_chan)
   );

endmodule

[sim/rc_serial_frame_parser_tb.sv]
// Self-checking testbench for rc_serial_frame_parser: serial frames, gap events and
// noise go in, and each result beat is compared with a cycle-free parser model.
// Depends on rcfp_pkg, rcfp_req_if, rcfp_rsp_if and the rc_serial_frame_parser RTL.
`timescale 1ns / 100ps

module rc_serial_frame_parser_tb;
   import rcfp_pkg::*;

   localparam int DATA_DEPTH = 32;
   localparam int CYCLE_LIMIT = 500000;
   localparam int ITEMS_PER_PHASE = 110;

   // Input beat kinds.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_GAP  = 1'b1;

   typedef struct {
      logic       cmd;
      logic [7:0] value;
   } serial_item_type;

   typedef struct {
      logic [1:0]  status;
      logic [7:0]  frame_type;
      logic [4:0]  byte_index;
      logic [7:0]  data_byte;
      logic        last;
      logic [15:0] error_count;
   } parser_result_type;

   logic clock;
   logic reset;

   rcfp_req_if req_if ();
   rcfp_rsp_if rsp_if ();

   rc_serial_frame_parser #(
      .DATA_DEPTH(DATA_DEPTH)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   serial_item_type   pending_items[$];
   parser_result_type frame_output_q[$];
   int                mismatch_count = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                cycle_count = 0;

   // Parser model state.
   logic [2:0]  parser_phase;
   logic [7:0]  bytes_remaining;
   logic [15:0] sum_acc;
   logic [7:0]  frame_type_held;
   logic [5:0]  fill_pos;
   logic [7:0]  checksum_low;
   logic [7:0]  frame_data[DATA_DEPTH];
   logic [15:0] crc_fail_total;

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // All inputs start at known values.
   initial begin
      req_if.valid      = 1'b0;
      req_if.cmd        = CMD_BYTE;
      req_if.byte_value = 8'h00;
      rsp_if.ready      = 1'b0;
   end

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Returns the parser model to the state that waits for a length byte.
   task automatic resync_parser();
      parser_phase    = PH_LEN;
      bytes_remaining = 8'd0;
      sum_acc         = SUM_INIT;
      fill_pos        = '0;
   endtask

   task automatic add_frame_output(input logic [1:0] status, input logic [7:0] ftype,
                                   input int idx, input logic [7:0] data, input logic last);
      parser_result_type r;
      r.status      = status;
      r.frame_type  = ftype;
      r.byte_index  = idx[4:0];
      r.data_byte   = data;
      r.last        = last;
      r.error_count = crc_fail_total;
      frame_output_q.push_back(r);
   endtask

   // Advances the parser model by one accepted beat and queues the results it causes.
   task automatic parse_serial_beat(input logic cmd, input logic [7:0] ch);
      int cnt;
      if (cmd == CMD_GAP) begin
         resync_parser();
         return;
      end
      case (parser_phase)
         PH_TYPE: begin
            bytes_remaining = bytes_remaining - 8'd1;
            sum_acc         = sum_acc - {8'h00, ch};
            frame_type_held = ch;
            parser_phase    = (bytes_remaining > 8'd2) ? PH_DATA : PH_CRC_LO;
         end
         PH_DATA: begin
            if (fill_pos < DATA_DEPTH) frame_data[fill_pos] = ch;
            fill_pos        = fill_pos + 6'd1;
            bytes_remaining = bytes_remaining - 8'd1;
            sum_acc         = sum_acc - {8'h00, ch};
            if (bytes_remaining <= 8'd2) parser_phase = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            checksum_low = ch;
            parser_phase = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            if ({ch, checksum_low} == sum_acc) begin
               if (fill_pos == 0) begin
                  add_frame_output(ST_EMPTY, frame_type_held, 0, 8'h00, 1'b1);
               end else begin
                  cnt = (fill_pos > DATA_DEPTH) ? DATA_DEPTH : int'(fill_pos);
                  for (int i = 0; i < cnt; i++)
                     add_frame_output(ST_DATA, frame_type_held, i, frame_data[i],
                                      i + 1 == cnt);
               end
            end else begin
               if (crc_fail_total != 16'hFFFF) crc_fail_total = crc_fail_total + 16'd1;
               add_frame_output(ST_CRC_ERR, frame_type_held, 0, 8'h00, 1'b1);
            end
            resync_parser();
         end
         default: begin
            // Expect a length byte; short or oversized lengths are rejected.
            if (int'(ch) < 4 || int'(ch) - 4 > DATA_DEPTH) begin
               add_frame_output(ST_LEN_ERR, 8'h00, 0, 8'h00, 1'b1);
               resync_parser();
            end else begin
               bytes_remaining = ch - 8'd1;
               sum_acc         = SUM_INIT - {8'h00, ch};
               fill_pos        = '0;
               parser_phase    = PH_TYPE;
            end
         end
      endcase
   endtask

   task automatic queue_item(input logic cmd, input logic [7:0] value);
      serial_item_type it;
      it.cmd   = cmd;
      it.value = value;
      pending_items.push_back(it);
   endtask

   // Builds a frame with n_data data bytes and pushes its first n_sent bytes.
   // A negative fill gives random data; a bad checksum is a corrupted good one.
   task automatic queue_frame(input int n_data, input logic [7:0] ftype, input bit good_sum,
                              input int fill, input int n_sent);
      logic [7:0]  fb[DATA_DEPTH + 4];
      logic [15:0] sum;
      int          total;
      total = n_data + 4;
      fb[0] = total[7:0];
      fb[1] = ftype;
      sum   = SUM_INIT - {8'h00, fb[0]} - {8'h00, fb[1]};
      for (int i = 0; i < n_data; i++) begin
         fb[2 + i] = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
         sum       = sum - {8'h00, fb[2 + i]};
      end
      if (!good_sum) sum = sum ^ 16'($urandom_range(65535, 1));
      fb[total - 2] = sum[7:0];
      fb[total - 1] = sum[15:8];
      for (int i = 0; i < total && i < n_sent; i++) queue_item(CMD_BYTE, fb[i]);
   endtask

   task automatic queue_directed();
      // Rejected lengths: zero, just under the minimum, just over the buffer, maximum.
      queue_item(CMD_BYTE, 8'd0);
      queue_item(CMD_BYTE, 8'd3);
      queue_item(CMD_BYTE, 8'(DATA_DEPTH + 5));
      queue_item(CMD_BYTE, 8'hFF);
      // A gap while already waiting for a length.
      queue_item(CMD_GAP, 8'hFF);
      // Empty frames with good and bad checksums, extreme type bytes.
      queue_frame(0, 8'hFF, 1'b1, -1, 99);
      queue_frame(0, 8'h00, 1'b0, -1, 99);
      // Short data frames with all-ones and all-zeros data.
      queue_frame(1, 8'h00, 1'b1, 8'hFF, 99);
      queue_frame(2, 8'hA5, 1'b1, 8'h00, 99);
      // A gap between the two checksum bytes drops the frame.
      queue_frame(0, 8'h3C, 1'b1, -1, 3);
      queue_item(CMD_GAP, 8'h00);
   endtask

   // Mostly well-formed frames with random content, plus gaps, noise and cut frames.
   task automatic queue_random_traffic(input int n_items);
      int start_size;
      int n_data;
      int sel;
      start_size = pending_items.size();
      while (pending_items.size() - start_size < n_items) begin
         sel = $urandom_range(99);
         if ($urandom_range(7) == 0) n_data = DATA_DEPTH;
         else if ($urandom_range(3) == 0) n_data = $urandom_range(DATA_DEPTH);
         else n_data = $urandom_range(6);
         if (sel < 65) begin
            if ($urandom_range(2) == 0) queue_item(CMD_GAP, 8'($urandom_range(255)));
            queue_frame(n_data, 8'($urandom_range(255)), $urandom_range(3) != 0, -1, 99);
         end else if (sel < 75) begin
            queue_item(CMD_GAP, 8'($urandom_range(255)));
         end else if (sel < 85) begin
            queue_item(CMD_BYTE, 8'($urandom_range(255)));
         end else begin
            queue_frame(n_data, 8'($urandom_range(255)), 1'b1, -1,
                        $urandom_range(n_data + 3, 1));
            queue_item(CMD_GAP, 8'($urandom_range(255)));
         end
      end
   endtask

   task automatic wait_until_drained();
      while (pending_items.size() != 0 || req_if.valid || frame_output_q.size() != 0)
         @(negedge clock);
   endtask

   // Input driver: presents the next pending beat and updates the model on each accept.
   always @(posedge clock) begin : serial_driver
      serial_item_type next_item;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) parse_serial_beat(req_if.cmd, req_if.byte_value);
         if (!req_if.valid || req_if.ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = pending_items.pop_front();
               req_if.valid      <= 1'b1;
               req_if.cmd        <= next_item.cmd;
               req_if.byte_value <= next_item.value;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks every accepted result beat against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      parser_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (frame_output_q.size() == 0) begin
               report_error($sformatf("unexpected result beat, status %0d type 0x%02h",
                                      rsp_if.status, rsp_if.frame_type));
            end else begin
               want = frame_output_q.pop_front();
               if (rsp_if.status !== want.status)
                  report_error($sformatf("status got %0d expected %0d",
                                         rsp_if.status, want.status));
               if (rsp_if.frame_type !== want.frame_type)
                  report_error($sformatf("frame_type got 0x%02h expected 0x%02h",
                                         rsp_if.frame_type, want.frame_type));
               if (rsp_if.byte_index !== want.byte_index)
                  report_error($sformatf("byte_index got %0d expected %0d",
                                         rsp_if.byte_index, want.byte_index));
               if (rsp_if.data_byte !== want.data_byte)
                  report_error($sformatf("data_byte got 0x%02h expected 0x%02h",
                                         rsp_if.data_byte, want.data_byte));
               if (rsp_if.last !== want.last)
                  report_error($sformatf("last got %0d expected %0d",
                                         rsp_if.last, want.last));
               if (rsp_if.error_count !== want.error_count)
                  report_error($sformatf("error_count got %0d expected %0d",
                                         rsp_if.error_count, want.error_count));
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Timeout watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rc_serial_frame_parser test failed");
      $finish;
   end

   // Reset, then three traffic phases with different idle patterns.
   initial begin
      reset = 1'b1;
      resync_parser();
      frame_type_held = 8'h00;
      checksum_low    = 8'h00;
      crc_fail_total  = 16'h0000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int phase_no = 0; phase_no < 3; phase_no++) begin
         @(negedge clock);
         case (phase_no)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 74;
               queue_directed();
            end
            1: begin
               send_idle_pct = 74;
               recv_idle_pct = 20;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         queue_random_traffic(ITEMS_PER_PHASE);
         wait_until_drained();
      end

      // Let any stray beat come out before the verdict.
      repeat (20) @(posedge clock);
      if (frame_output_q.size() != 0)
         report_error($sformatf("%0d expected results never arrived", frame_output_q.size()));
      if (mismatch_count == 0) begin
         $display("rc_serial_frame_parser test passed");
      end else begin
         $display("rc_serial_frame_parser test failed");
      end
      $finish;
   end

endmodule
